[rtl/core/tcp_pkg.sv]
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared constants and types for the triangle cull and projection core.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 6;
  localparam int DIV_STEPS = 63;
  localparam int LANE_LAT  = DIV_STEPS + 5;
  localparam int CULL_LAT  = 6;
  localparam int CFG_IDX_W = 4;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [32:0] zfix_t;
  typedef logic [12:0]        size_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Z_OFFSET = 4'd0,
    REG_CAM_X    = 4'd1,
    REG_CAM_Y    = 4'd2,
    REG_CAM_Z    = 4'd3,
    REG_X_GAIN   = 4'd4,
    REG_Y_GAIN   = 4'd5,
    REG_SCR_W    = 4'd6,
    REG_SCR_H    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

endpackage

[rtl/core/tcp_lane.sv]
// ----------------------------------------------------------------------------
// tcp_lane
// One coordinate lane: gain multiply, pipelined divide by z, viewport map.
// ----------------------------------------------------------------------------
module tcp_lane (
  input  logic             clk,
  input  tcp_pkg::pipe_ctl_t ctl,
  input  tcp_pkg::fix_t    coord,
  input  tcp_pkg::fix_t    gain,
  input  tcp_pkg::zfix_t   z,
  input  tcp_pkg::size_t   size,
  output tcp_pkg::fix_t    scr
);
  import tcp_pkg::*;

  logic signed [63:0] num;
  zfix_t              z1;
  logic [32:0]        rem [0:DIV_STEPS];
  logic [62:0]        qd  [0:DIV_STEPS];
  logic [32:0]        dv  [0:DIV_STEPS];
  logic               ng  [0:DIV_STEPS];
  logic               zf  [0:DIV_STEPS];
  logic signed [63:0] zv  [0:DIV_STEPS];
  logic [32:0]        rem_nx [0:DIV_STEPS-1];
  logic               qbit   [0:DIV_STEPS-1];
  logic signed [63:0] num_abs;
  zfix_t              z_abs;
  logic signed [63:0] c_val;
  logic signed [63:0] t_val;
  logic signed [41:0] t_cl;
  logic signed [55:0] prod;
  logic signed [55:0] half;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] LIM = 64'sd1 <<< 40;
  localparam logic signed [55:0] SMAX = 56'sd2147483647;
  localparam logic signed [55:0] SMIN = -56'sd2147483648;

  assign num_abs = num[63] ? -num : num;
  assign z_abs   = z1[32] ? -z1 : z1;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [34:0] diff;
      diff = {1'b0, rem[k], qd[k][62]} - {2'b00, dv[k]};
      qbit[k] = ~diff[34];
      rem_nx[k] = diff[34] ? {rem[k][31:0], qd[k][62]} : diff[32:0];
    end
  end

  assign c_val = zf[DIV_STEPS] ? zv[DIV_STEPS] :
                 (ng[DIV_STEPS] ? -$signed({1'b0, qd[DIV_STEPS]}) :
                                   $signed({1'b0, qd[DIV_STEPS]}));
  assign t_val = c_val + ONE;
  assign half  = prod >>> 1;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      num <= 64'(coord) * 64'(gain);
      z1  <= z;
      rem[0] <= '0;
      qd[0]  <= num_abs[62:0];
      dv[0]  <= z_abs;
      ng[0]  <= num[63] ^ z1[32];
      zf[0]  <= (z1 == '0);
      zv[0]  <= num >>> FRAC_BITS;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem[k+1] <= rem_nx[k];
        qd[k+1]  <= {qd[k][61:0], qbit[k]};
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        zf[k+1]  <= zf[k];
        zv[k+1]  <= zv[k];
      end
      if (t_val > LIM) begin
        t_cl <= LIM[41:0];
      end else if (t_val < -LIM) begin
        t_cl <= 42'(-LIM);
      end else begin
        t_cl <= t_val[41:0];
      end
      prod <= 56'(t_cl) * $signed({43'b0, size});
      if (half > SMAX) begin
        scr <= SMAX[31:0];
      end else if (half < SMIN) begin
        scr <= SMIN[31:0];
      end else begin
        scr <= half[31:0];
      end
    end
  end

endmodule

[rtl/core/tcp_cull.sv]
// ----------------------------------------------------------------------------
// tcp_cull
// Back-face test: edge cross product dotted with the view vector, exact.
// ----------------------------------------------------------------------------
module tcp_cull (
  input  logic               clk,
  input  tcp_pkg::pipe_ctl_t ctl,
  input  tcp_pkg::fix_t      vx [3],
  input  tcp_pkg::fix_t      vy [3],
  input  tcp_pkg::zfix_t     vz [3],
  input  tcp_pkg::fix_t      cam_x,
  input  tcp_pkg::fix_t      cam_y,
  input  tcp_pkg::fix_t      cam_z,
  output logic               vis
);
  import tcp_pkg::*;

  localparam int DLY = LANE_LAT - CULL_LAT;

  logic signed [33:0]  e1 [3];
  logic signed [33:0]  e2 [3];
  logic signed [33:0]  d1 [3];
  logic signed [33:0]  d2 [3];
  logic signed [33:0]  d3 [3];
  logic signed [33:0]  d4 [3];
  logic signed [67:0]  pa [3];
  logic signed [67:0]  pb [3];
  logic signed [68:0]  n  [3];
  logic signed [67:0]  ph [3];
  logic signed [69:0]  pl [3];
  logic signed [103:0] cp [3];
  logic                vis6;
  logic [DLY-1:0]      vis_dly;
  logic signed [105:0] dot;

  assign dot = 106'(cp[0]) + 106'(cp[1]) + 106'(cp[2]);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      e1[0] <= 34'(vx[1]) - 34'(vx[0]);
      e1[1] <= 34'(vy[1]) - 34'(vy[0]);
      e1[2] <= 34'(vz[1]) - 34'(vz[0]);
      e2[0] <= 34'(vx[2]) - 34'(vx[0]);
      e2[1] <= 34'(vy[2]) - 34'(vy[0]);
      e2[2] <= 34'(vz[2]) - 34'(vz[0]);
      d1[0] <= 34'(vx[0]) - 34'(cam_x);
      d1[1] <= 34'(vy[0]) - 34'(cam_y);
      d1[2] <= 34'(vz[0]) - 34'(cam_z);
      pa[0] <= 68'(e1[1]) * 68'(e2[2]);
      pb[0] <= 68'(e1[2]) * 68'(e2[1]);
      pa[1] <= 68'(e1[2]) * 68'(e2[0]);
      pb[1] <= 68'(e1[0]) * 68'(e2[2]);
      pa[2] <= 68'(e1[0]) * 68'(e2[1]);
      pb[2] <= 68'(e1[1]) * 68'(e2[0]);
      for (int i = 0; i < 3; i++) begin
        d2[i] <= d1[i];
        d3[i] <= d2[i];
        n[i]  <= 69'(pa[i]) - 69'(pb[i]);
        ph[i] <= 68'($signed(n[i][68:35])) * 68'(d3[i]);
        pl[i] <= 70'($signed({1'b0, n[i][34:0]})) * 70'(d3[i]);
        cp[i] <= (104'(ph[i]) <<< 35) + 104'(pl[i]);
      end
      vis6    <= dot[105];
      vis_dly <= {vis_dly[DLY-2:0], vis6};
    end
  end

  assign vis = vis_dly[DLY-1];

endmodule

[rtl/core/tcp_merge.sv]
// ----------------------------------------------------------------------------
// tcp_merge
// Output register: joins the lane results with the cull verdict.
// ----------------------------------------------------------------------------
module tcp_merge (
  input  logic               clk,
  input  logic               rst,
  input  tcp_pkg::pipe_ctl_t ctl,
  input  logic               vld,
  input  tcp_pkg::fix_t      lane [tcp_pkg::NUM_LANES],
  input  logic               vis,
  output logic               out_valid,
  output tcp_pkg::fix_t      res [tcp_pkg::NUM_LANES],
  output logic               res_vis
);
  import tcp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res_vis <= vis;
      for (int i = 0; i < NUM_LANES; i++) begin
        res[i] <= vis ? lane[i] : '0;
      end
    end
  end

endmodule

[rtl/core/triangle_cull_and_project_core.sv]
// ----------------------------------------------------------------------------
// triangle_cull_and_project_core
// Each coordinate lane holds a 63-step pipelined divider.
// Throughput: one triangle per cycle while the output is not stalled; a
// one-item input skid register keeps in_ready high during an output stall
// until it holds an item.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module triangle_cull_and_project_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tcp_pkg::fix_t                    v0_x,
  input  tcp_pkg::fix_t                    v0_y,
  input  tcp_pkg::fix_t                    v0_z,
  input  tcp_pkg::fix_t                    v1_x,
  input  tcp_pkg::fix_t                    v1_y,
  input  tcp_pkg::fix_t                    v1_z,
  input  tcp_pkg::fix_t                    v2_x,
  input  tcp_pkg::fix_t                    v2_y,
  input  tcp_pkg::fix_t                    v2_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tcp_pkg::fix_t                    s0_x,
  output tcp_pkg::fix_t                    s0_y,
  output tcp_pkg::fix_t                    s1_x,
  output tcp_pkg::fix_t                    s1_y,
  output tcp_pkg::fix_t                    s2_x,
  output tcp_pkg::fix_t                    s2_y,
  output logic                             visible
);
  import tcp_pkg::*;

  fix_t  z_offset, cam_x, cam_y, cam_z, x_gain, y_gain;
  size_t screen_width, screen_height;

  logic         adv;
  pipe_ctl_t    ctl;
  logic         skid_vld;
  fix_t         skid [9];
  fix_t         src  [9];
  fix_t         in_bus [9];
  logic [LANE_LAT:0] pipe_vld;
  fix_t         ax [3];
  fix_t         ay [3];
  zfix_t        az [3];
  fix_t         lane_res [NUM_LANES];
  fix_t         res [NUM_LANES];
  logic         cull_vis;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign ctl.en    = adv;
  assign in_ready  = !skid_vld;

  assign in_bus[0] = v0_x;
  assign in_bus[1] = v0_y;
  assign in_bus[2] = v0_z;
  assign in_bus[3] = v1_x;
  assign in_bus[4] = v1_y;
  assign in_bus[5] = v1_z;
  assign in_bus[6] = v2_x;
  assign in_bus[7] = v2_y;
  assign in_bus[8] = v2_z;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      src[i] = skid_vld ? skid[i] : in_bus[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z_offset      <= 32'sd196608;
      cam_x         <= '0;
      cam_y         <= '0;
      cam_z         <= '0;
      x_gain        <= 32'sd65536;
      y_gain        <= 32'sd65536;
      screen_width  <= 13'd1000;
      screen_height <= 13'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_Z_OFFSET: z_offset      <= cfg_data;
        REG_CAM_X:    cam_x         <= cfg_data;
        REG_CAM_Y:    cam_y         <= cfg_data;
        REG_CAM_Z:    cam_z         <= cfg_data;
        REG_X_GAIN:   x_gain        <= cfg_data;
        REG_Y_GAIN:   y_gain        <= cfg_data;
        REG_SCR_W:    screen_width  <= cfg_data[12:0];
        REG_SCR_H:    screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
      pipe_vld <= '0;
    end else if (adv) begin
      skid_vld <= 1'b0;
      pipe_vld <= {pipe_vld[LANE_LAT-1:0], skid_vld || in_valid};
    end else if (in_valid && in_ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && in_ready) begin
      skid <= in_bus;
    end
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        ax[v] <= src[3*v];
        ay[v] <= src[3*v+1];
        az[v] <= 33'(src[3*v+2]) + 33'(z_offset);
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tcp_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .coord ((g % 2 == 0) ? ax[g/2] : ay[g/2]),
      .gain  ((g % 2 == 0) ? x_gain : y_gain),
      .z     (az[g/2]),
      .size  ((g % 2 == 0) ? screen_width : screen_height),
      .scr   (lane_res[g])
    );
  end

  tcp_cull u_cull (
    .clk   (clk),
    .ctl   (ctl),
    .vx    (ax),
    .vy    (ay),
    .vz    (az),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (cam_z),
    .vis   (cull_vis)
  );

  tcp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .vld       (pipe_vld[LANE_LAT]),
    .lane      (lane_res),
    .vis       (cull_vis),
    .out_valid (out_valid),
    .res       (res),
    .res_vis   (visible)
  );

  assign s0_x = res[0];
  assign s0_y = res[1];
  assign s1_x = res[2];
  assign s1_y = res[3];
  assign s2_x = res[4];
  assign s2_y = res[5];

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> pipe_vld == $past(pipe_vld))
    else $error("pipeline moved during an output stall");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !adv |=> skid_vld)
    else $error("skid item lost during a stall");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !adv |=> skid_vld)
    else $error("item accepted in a stall was not held");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_vld && adv |=> pipe_vld[0])
    else $error("skid item did not enter the pipeline");

endmodule

[bench/tb_triangle_cull_and_project_core.sv]
// ----------------------------------------------------------------------------
// Triangle cull and projection core testbench
// Drives triangles through the valid/ready input channel under random gaps,
// stalls the result channel at random and once for a long stretch, and
// rewrites every register between phases, its extremes included. A
// scoreboard predicts the visibility flag and the saturated screen
// coordinates of each triangle and compares them field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_triangle_cull_and_project_core;
  import tcp_pkg::*;

  localparam int  ITEMS_PER_PHASE = 257;
  localparam int  DRAIN_CYCLES    = 80;
  localparam longint CYCLE_LIMIT  = 600000;

  typedef fix_t tri_t[9];

  typedef struct {
    fix_t sx[3];
    fix_t sy[3];
    logic vis;
  } screen_tri_t;

  class tri_scoreboard;
    longint      z_offset, cam_x, cam_y, cam_z, x_gain, y_gain;
    longint      scr_w, scr_h;
    screen_tri_t pending_tris[$];
    int          errors;

    function new();
      z_offset = 64'sd3 <<< FRAC_BITS;
      cam_x = 0;
      cam_y = 0;
      cam_z = 0;
      x_gain = 64'sd1 <<< FRAC_BITS;
      y_gain = 64'sd1 <<< FRAC_BITS;
      scr_w = 1000;
      scr_h = 1000;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_Z_OFFSET: z_offset = longint'(fix_t'(d));
        REG_CAM_X:    cam_x = longint'(fix_t'(d));
        REG_CAM_Y:    cam_y = longint'(fix_t'(d));
        REG_CAM_Z:    cam_z = longint'(fix_t'(d));
        REG_X_GAIN:   x_gain = longint'(fix_t'(d));
        REG_Y_GAIN:   y_gain = longint'(fix_t'(d));
        REG_SCR_W:    scr_w = longint'({51'd0, d[12:0]});
        REG_SCR_H:    scr_h = longint'({51'd0, d[12:0]});
        default: ;
      endcase
    endfunction

    function longint project(longint c, longint gain, longint z);
      longint num;
      num = c * gain;
      if (z != 0) return num / z;
      return num >>> FRAC_BITS;
    endfunction

    function fix_t to_pixels(longint c, longint size);
      longint lim, t, p;
      lim = 64'sd1 <<< 40;
      t = c + (64'sd1 <<< FRAC_BITS);
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      p = (t * size) >>> 1;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return fix_t'(p[31:0]);
    endfunction

    function void note(tri_t v);
      longint vx[3], vy[3], vz[3];
      logic signed [127:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, dot;
      logic signed [127:0] px, py, pz;
      screen_tri_t r;
      for (int i = 0; i < 3; i++) begin
        vx[i] = longint'(v[3*i]);
        vy[i] = longint'(v[3*i+1]);
        vz[i] = longint'(v[3*i+2]) + z_offset;
      end
      e1x = vx[1] - vx[0];
      e1y = vy[1] - vy[0];
      e1z = vz[1] - vz[0];
      e2x = vx[2] - vx[0];
      e2y = vy[2] - vy[0];
      e2z = vz[2] - vz[0];
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      px = vx[0] - cam_x;
      py = vy[0] - cam_y;
      pz = vz[0] - cam_z;
      dot = nx * px + ny * py + nz * pz;
      r.vis = dot[127];
      for (int i = 0; i < 3; i++) begin
        if (r.vis) begin
          r.sx[i] = to_pixels(project(vx[i], x_gain, vz[i]), scr_w);
          r.sy[i] = to_pixels(project(vy[i], y_gain, vz[i]), scr_h);
        end else begin
          r.sx[i] = '0;
          r.sy[i] = '0;
        end
      end
      pending_tris.push_back(r);
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check(screen_tri_t got);
      screen_tri_t want;
      if (pending_tris.size() == 0) begin
        report("unexpected result item", 0, 1);
        return;
      end
      want = pending_tris.pop_front();
      if (got.vis !== want.vis) report("visible", want.vis, got.vis);
      for (int i = 0; i < 3; i++) begin
        if (got.sx[i] !== want.sx[i]) report($sformatf("s%0d_x", i), want.sx[i], got.sx[i]);
        if (got.sy[i] !== want.sy[i]) report($sformatf("s%0d_y", i), want.sy[i], got.sy[i]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  fix_t        v0_x = '0, v0_y = '0, v0_z = '0;
  fix_t        v1_x = '0, v1_y = '0, v1_z = '0;
  fix_t        v2_x = '0, v2_y = '0, v2_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  fix_t        s0_x, s0_y, s1_x, s1_y, s2_x, s2_y;
  logic        visible;

  logic        in_fire = 1'b0, out_fire = 1'b0, cfg_fire = 1'b0;
  longint      cycles = 0;
  int          results_seen = 0;
  bit          burst_mode = 1'b0;
  tri_scoreboard sb = new();

  triangle_cull_and_project_core i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    screen_tri_t got;
    in_fire  <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    cycles   <= cycles + 1;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note('{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z});
      if (out_valid && out_ready) begin
        got.sx[0] = s0_x;
        got.sy[0] = s0_y;
        got.sx[1] = s1_x;
        got.sy[1] = s1_y;
        got.sx[2] = s2_x;
        got.sy[2] = s2_y;
        got.vis = visible;
        sb.check(got);
        results_seen <= results_seen + 1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid = 1'b0;
  endtask

  task automatic send_tri(tri_t v);
    int gap;
    gap = draw_gap();
    repeat (gap) @(negedge clk);
    {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} =
      {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    in_valid = 1'b1;
    do @(negedge clk); while (!in_fire);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending_tris.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic fix_t pick_edge();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return fix_t'($urandom());
    endcase
  endfunction

  function automatic tri_t random_tri();
    tri_t v;
    int kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 9; i++) begin
      if (kind < 14) v[i] = fix_t'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
      else if (kind < 17) v[i] = fix_t'($urandom());
      else v[i] = pick_edge();
    end
    if (kind == 0) begin
      v[6] = v[0];
      v[7] = v[1];
      v[8] = v[2];
    end
    if (kind == 1) v[3 * $urandom_range(0, 2) + 2] = fix_t'(-sb.z_offset);
    return v;
  endfunction

  task automatic random_phase();
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_tri(random_tri());
    end
    burst_mode = 1'b0;
  endtask

  task automatic write_all(logic [31:0] z, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] cz, logic [31:0] gx, logic [31:0] gy,
                           logic [31:0] w, logic [31:0] h);
    write_reg(REG_Z_OFFSET, z);
    write_reg(REG_CAM_X, cx);
    write_reg(REG_CAM_Y, cy);
    write_reg(REG_CAM_Z, cz);
    write_reg(REG_X_GAIN, gx);
    write_reg(REG_Y_GAIN, gy);
    write_reg(REG_SCR_W, w);
    write_reg(REG_SCR_H, h);
  endtask

  always begin
    int gap;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        gap = 400;
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(negedge clk); while (!out_fire);
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Extremes, zero depth, degenerate and simply wound triangles at reset values.
    send_tri('{default: '0});
    send_tri('{default: 32'sh7fffffff});
    send_tri('{default: 32'sh80000000});
    send_tri('{default: -32'sd1});
    send_tri('{-32'sh10000, -32'sh10000, 0, 32'sh10000, -32'sh10000, 0, 0, 32'sh10000, 0});
    send_tri('{-32'sh10000, -32'sh10000, 0, 0, 32'sh10000, 0, 32'sh10000, -32'sh10000, 0});
    send_tri('{-32'sh10000, 32'sh8000, -32'sh30000, 32'sh10000, -32'sh10000, 0,
               0, 32'sh10000, 0});
    send_tri('{32'sh10000, 32'sh20000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh10000,
               32'sh30000, 32'sh40000, 32'sh50000});
    send_tri('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    send_tri('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000});
    random_phase();
    wait_idle();

    write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'd4096, 32'd1);
    random_phase();
    wait_idle();

    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
    random_phase();
    wait_idle();

    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h0, 32'h0);
    random_phase();
    wait_idle();

    write_all(32'h50000, 32'hfffe0000, 32'h18000, 32'hffff0000,
              32'h1c000, 32'h12000, 32'd640, 32'd480);
    random_phase();
    wait_idle();

    write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom());
    random_phase();
    wait_idle();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tcp_pkg.sv
rtl/core/tcp_lane.sv
rtl/core/tcp_cull.sv
rtl/core/tcp_merge.sv
rtl/core/triangle_cull_and_project_core.sv
bench/tb_triangle_cull_and_project_core.sv
